// ----- rtl/tfe_pkg.sv -----
package tfe_pkg;

   // default sizes
   localparam int MAX_STATES_DEF      = 64;
   localparam int MAX_TRANSITIONS_DEF = 64;
   localparam int NUM_CONDITIONS_DEF  = 32;
   localparam int MAX_DO_ACTIONS_DEF  = 15;

   // field widths
   localparam int ID_W    = 8;
   localparam int IDX_W   = 6;
   localparam int DO_W    = 4;
   localparam int SEL_W   = 5;
   localparam int COND_W  = 32;
   localparam int CNT_W   = 7;
   localparam int ATTR_W  = 6;
   localparam int SENT_W  = ID_W + ATTR_W;
   localparam int TENT_W  = 2 * ID_W + SEL_W + 1;

   typedef enum logic [1:0] {
      REQ_RUN         = 2'd0,
      REQ_WRITE_STATE = 2'd1,
      REQ_WRITE_TRANS = 2'd2,
      REQ_SET_INIT    = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK             = 2'd0,
      ST_INIT_NOT_FOUND = 2'd1,
      ST_NOT_STARTED    = 2'd2,
      ST_TARGET_MISSING = 2'd3
   } status_type;

   // csr register indexes
   localparam logic CSR_STATE_COUNT      = 1'b0;
   localparam logic CSR_TRANSITION_COUNT = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic       latch;
      logic       wr_state;
      logic       wr_trans;
      logic       scan_start;
      logic       scan_lookup;
      logic       set_init;
      logic       set_target;
      logic       respond;
      status_type resp_status;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
      logic scan_hit;
      logic started;
   } stat_type;

endpackage

// ----- rtl/table_driven_fsm_engine.sv -----
// channel   ports                      transfer
// request   start, busy, req_*         start high while busy low
// result    rsp_valid, rsp_*           one cycle pulse, always taken
// config    csr_valid, csr_ready, csr_* valid and ready high, ready always high
//
// a load request passes the load and done states before its result strobe is registered
// set initial scans the state table, a run step the transition table and then,
// on a hit, the state table: each table sits in a registered-read ram
// and the scan sequencer reads one entry per cycle, comparing in the next cycle
// reset is synchronous and clears control state only, tables have no clearing pass
// busy stays high until the result is registered; the result side cannot stall
module table_driven_fsm_engine #(
   parameter int MAX_STATES      = tfe_pkg::MAX_STATES_DEF,
   parameter int MAX_TRANSITIONS = tfe_pkg::MAX_TRANSITIONS_DEF,
   parameter int NUM_CONDITIONS  = tfe_pkg::NUM_CONDITIONS_DEF,
   parameter int MAX_DO_ACTIONS  = tfe_pkg::MAX_DO_ACTIONS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_type,
   input  logic [tfe_pkg::IDX_W-1:0]   req_entry_index,
   input  logic [tfe_pkg::ID_W-1:0]    req_state_id,
   input  logic                        req_has_entry_action,
   input  logic                        req_has_exit_action,
   input  logic [tfe_pkg::DO_W-1:0]    req_do_action_count,
   input  logic [tfe_pkg::ID_W-1:0]    req_from_state_id,
   input  logic [tfe_pkg::ID_W-1:0]    req_to_state_id,
   input  logic [tfe_pkg::SEL_W-1:0]   req_condition_select,
   input  logic                        req_condition_present,
   input  logic [tfe_pkg::COND_W-1:0]  req_condition_bits,
   // result channel
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_status,
   output logic [tfe_pkg::ID_W-1:0]    rsp_current_state_id,
   output logic                        rsp_current_valid,
   output logic                        rsp_transitioned,
   output logic                        rsp_exit_strobe,
   output logic                        rsp_entry_strobe,
   output logic [tfe_pkg::DO_W-1:0]    rsp_do_count,
   output logic [tfe_pkg::ID_W-1:0]    rsp_previous_state_id,
   output logic [tfe_pkg::IDX_W-1:0]   rsp_taken_index,
   // configuration channel
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic                        csr_index,
   input  logic [tfe_pkg::CNT_W-1:0]   csr_wdata
);

   tfe_pkg::cmd_type  cmd;
   tfe_pkg::stat_type stat;

   // register writes must arrive only while idle (unchecked); they are always taken
   assign csr_ready = 1'b1;

   // sequencer: dispatch on request type, waits on scan done / hit
   tfe_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .busy     (busy),
      .stat     (stat),
      .cmd      (cmd)
   );

   // tables, current state cache, scan unit and result registers
   tfe_datapath #(
      .MAX_STATES      (MAX_STATES),
      .MAX_TRANSITIONS (MAX_TRANSITIONS),
      .NUM_CONDITIONS  (NUM_CONDITIONS),
      .MAX_DO_ACTIONS  (MAX_DO_ACTIONS)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .stat                  (stat),
      .csr_valid             (csr_valid),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_type              (req_type),
      .req_entry_index       (req_entry_index),
      .req_state_id          (req_state_id),
      .req_has_entry_action  (req_has_entry_action),
      .req_has_exit_action   (req_has_exit_action),
      .req_do_action_count   (req_do_action_count),
      .req_from_state_id     (req_from_state_id),
      .req_to_state_id       (req_to_state_id),
      .req_condition_select  (req_condition_select),
      .req_condition_present (req_condition_present),
      .req_condition_bits    (req_condition_bits),
      .rsp_valid             (rsp_valid),
      .rsp_status            (rsp_status),
      .rsp_current_state_id  (rsp_current_state_id),
      .rsp_current_valid     (rsp_current_valid),
      .rsp_transitioned      (rsp_transitioned),
      .rsp_exit_strobe       (rsp_exit_strobe),
      .rsp_entry_strobe      (rsp_entry_strobe),
      .rsp_do_count          (rsp_do_count),
      .rsp_previous_state_id (rsp_previous_state_id),
      .rsp_taken_index       (rsp_taken_index)
   );

endmodule

// ----- rtl/tfe_ram.sv -----
module tfe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/tfe_ctrl.sv -----
module tfe_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [1:0]       req_type,
   output logic             busy,
   input  tfe_pkg::stat_type stat,
   output tfe_pkg::cmd_type  cmd
);

   typedef enum logic [5:0] {
      S_IDLE      = 6'b000001,
      S_LOAD      = 6'b000010,
      S_LOOK_INIT = 6'b000100,
      S_SCAN      = 6'b001000,
      S_LOOK_TGT  = 6'b010000,
      S_DONE      = 6'b100000
   } fsm_type;

   fsm_type              state_ff, state_in;
   tfe_pkg::status_type  st_ff, st_in;

   always_comb begin
      state_in = state_ff;
      st_in    = st_ff;
      cmd      = '0;
      cmd.resp_status = st_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               st_in     = tfe_pkg::ST_OK;
               case (tfe_pkg::req_code_type'(req_type))
                  tfe_pkg::REQ_WRITE_STATE,
                  tfe_pkg::REQ_WRITE_TRANS: begin
                     state_in = S_LOAD;
                  end
                  tfe_pkg::REQ_SET_INIT: begin
                     cmd.scan_start  = 1'b1;
                     cmd.scan_lookup = 1'b1;
                     state_in        = S_LOOK_INIT;
                  end
                  default: begin
                     if (stat.started) begin
                        cmd.scan_start = 1'b1;
                        state_in       = S_SCAN;
                     end else begin
                        st_in    = tfe_pkg::ST_NOT_STARTED;
                        state_in = S_DONE;
                     end
                  end
               endcase
            end
         end
         S_LOAD: begin
            cmd.wr_state = 1'b1;
            cmd.wr_trans = 1'b1;
            state_in     = S_DONE;
         end
         S_LOOK_INIT: begin
            if (stat.scan_done) begin
               if (stat.scan_hit) begin
                  cmd.set_init = 1'b1;
               end else begin
                  st_in = tfe_pkg::ST_INIT_NOT_FOUND;
               end
               state_in = S_DONE;
            end
         end
         S_SCAN: begin
            if (stat.scan_done) begin
               if (stat.scan_hit) begin
                  cmd.scan_start  = 1'b1;
                  cmd.scan_lookup = 1'b1;
                  state_in        = S_LOOK_TGT;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_LOOK_TGT: begin
            if (stat.scan_done) begin
               if (stat.scan_hit) begin
                  cmd.set_target = 1'b1;
               end else begin
                  st_in = tfe_pkg::ST_TARGET_MISSING;
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         st_ff    <= tfe_pkg::ST_OK;
      end else begin
         state_ff <= state_in;
         st_ff    <= st_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ----- rtl/tfe_datapath.sv -----
module tfe_datapath #(
   parameter int MAX_STATES      = tfe_pkg::MAX_STATES_DEF,
   parameter int MAX_TRANSITIONS = tfe_pkg::MAX_TRANSITIONS_DEF,
   parameter int NUM_CONDITIONS  = tfe_pkg::NUM_CONDITIONS_DEF,
   parameter int MAX_DO_ACTIONS  = tfe_pkg::MAX_DO_ACTIONS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  tfe_pkg::cmd_type            cmd,
   output tfe_pkg::stat_type           stat,
   input  logic                        csr_valid,
   input  logic                        csr_index,
   input  logic [tfe_pkg::CNT_W-1:0]   csr_wdata,
   input  logic [1:0]                  req_type,
   input  logic [tfe_pkg::IDX_W-1:0]   req_entry_index,
   input  logic [tfe_pkg::ID_W-1:0]    req_state_id,
   input  logic                        req_has_entry_action,
   input  logic                        req_has_exit_action,
   input  logic [tfe_pkg::DO_W-1:0]    req_do_action_count,
   input  logic [tfe_pkg::ID_W-1:0]    req_from_state_id,
   input  logic [tfe_pkg::ID_W-1:0]    req_to_state_id,
   input  logic [tfe_pkg::SEL_W-1:0]   req_condition_select,
   input  logic                        req_condition_present,
   input  logic [tfe_pkg::COND_W-1:0]  req_condition_bits,
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_status,
   output logic [tfe_pkg::ID_W-1:0]    rsp_current_state_id,
   output logic                        rsp_current_valid,
   output logic                        rsp_transitioned,
   output logic                        rsp_exit_strobe,
   output logic                        rsp_entry_strobe,
   output logic [tfe_pkg::DO_W-1:0]    rsp_do_count,
   output logic [tfe_pkg::ID_W-1:0]    rsp_previous_state_id,
   output logic [tfe_pkg::IDX_W-1:0]   rsp_taken_index
);

   localparam int SAW  = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
   localparam int TAW  = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
   localparam int AW   = (SAW > TAW) ? SAW : TAW;
   localparam int MAXD = (MAX_STATES > MAX_TRANSITIONS) ? MAX_STATES : MAX_TRANSITIONS;
   localparam int CW   = $clog2(MAXD + 1);
   localparam int IW   = tfe_pkg::ID_W;

   // configuration
   logic [tfe_pkg::CNT_W-1:0] state_count_ff, trans_count_ff;

   // latched request
   tfe_pkg::req_code_type      type_ff;
   logic [tfe_pkg::IDX_W-1:0]  idx_ff;
   logic [IW-1:0]              sid_ff, from_ff, to_ff, tgt_ff;
   logic                       ent_ff, ext_ff, pres_ff;
   logic [tfe_pkg::DO_W-1:0]   doc_ff;
   logic [tfe_pkg::SEL_W-1:0]  sel_ff;
   logic [tfe_pkg::COND_W-1:0] conds_ff;

   // current state cache
   logic                       started_ff;
   logic [SAW-1:0]             cur_slot_ff;
   logic [IW-1:0]              cur_id_ff;
   logic [tfe_pkg::ATTR_W-1:0] cur_attr_ff;

   // scan sequencer
   logic           run_ff, pend_ff, lookup_ff;
   logic [CW-1:0]  ptr_ff, bound;
   logic [AW-1:0]  pend_addr_ff;
   logic           hit_now, issue, lookup_hit, trans_hit;
   logic [CW-1:0]  n_states, n_trans;
   logic [IW-1:0]  key;

   // result accumulation
   logic                      exs_ff, ens_ff, trd_ff;
   logic [tfe_pkg::DO_W-1:0]  dc_ff, dc_sat;
   logic [tfe_pkg::IDX_W-1:0] taken_ff;
   logic [IW-1:0]             prev_ff;

   // tables
   logic [tfe_pkg::SENT_W-1:0] s_wdata, s_rdata;
   logic [tfe_pkg::TENT_W-1:0] t_wdata, t_rdata;
   logic                       s_we, t_we, s_in_range;

   // output registers
   logic                      rsp_valid_ff;
   tfe_pkg::status_type       rsp_status_ff;
   logic [IW-1:0]             rsp_cur_ff, rsp_prev_ff;
   logic                      rsp_cv_ff, rsp_trd_ff, rsp_exs_ff, rsp_ens_ff;
   logic [tfe_pkg::DO_W-1:0]  rsp_dc_ff;
   logic [tfe_pkg::IDX_W-1:0] rsp_taken_ff;

   assign n_states = (int'(state_count_ff) > MAX_STATES) ? CW'(MAX_STATES)
                                                         : CW'(state_count_ff);
   assign n_trans  = (int'(trans_count_ff) > MAX_TRANSITIONS) ? CW'(MAX_TRANSITIONS)
                                                              : CW'(trans_count_ff);
   assign bound    = lookup_ff ? n_states : n_trans;
   assign key      = (type_ff == tfe_pkg::REQ_SET_INIT) ? sid_ff : tgt_ff;

   assign lookup_hit = (s_rdata[IW-1:0] == key);
   assign trans_hit  = (t_rdata[IW-1:0] == cur_id_ff) && t_rdata[tfe_pkg::TENT_W-1] &&
                       (int'(t_rdata[2*IW +: tfe_pkg::SEL_W]) < NUM_CONDITIONS) &&
                       conds_ff[t_rdata[2*IW +: tfe_pkg::SEL_W]];
   assign hit_now    = run_ff && pend_ff && (lookup_ff ? lookup_hit : trans_hit);
   assign issue      = run_ff && (ptr_ff < bound) && !hit_now;

   assign stat.scan_hit  = hit_now;
   assign stat.scan_done = hit_now || (run_ff && !pend_ff && !(ptr_ff < bound));
   assign stat.started   = started_ff;

   assign dc_sat = (int'(cur_attr_ff[tfe_pkg::ATTR_W-1:2]) > MAX_DO_ACTIONS)
                   ? tfe_pkg::DO_W'(MAX_DO_ACTIONS) : cur_attr_ff[tfe_pkg::ATTR_W-1:2];

   // state entry: attributes above id, attributes are {do count, exit, entry}
   assign s_in_range = (int'(idx_ff) < MAX_STATES);
   assign s_we    = cmd.wr_state && (type_ff == tfe_pkg::REQ_WRITE_STATE) && s_in_range;
   assign t_we    = cmd.wr_trans && (type_ff == tfe_pkg::REQ_WRITE_TRANS) &&
                    (int'(idx_ff) < MAX_TRANSITIONS);
   assign s_wdata = {doc_ff, ext_ff, ent_ff, sid_ff};
   assign t_wdata = {pres_ff, sel_ff, to_ff, from_ff};

   tfe_ram #(.WIDTH(tfe_pkg::SENT_W), .DEPTH(MAX_STATES)) u_state_ram (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (SAW'(idx_ff)),
      .wr_data (s_wdata),
      .rd_addr (ptr_ff[SAW-1:0]),
      .rd_data (s_rdata)
   );

   tfe_ram #(.WIDTH(tfe_pkg::TENT_W), .DEPTH(MAX_TRANSITIONS)) u_trans_ram (
      .clock   (clock),
      .wr_en   (t_we),
      .wr_addr (TAW'(idx_ff)),
      .wr_data (t_wdata),
      .rd_addr (ptr_ff[TAW-1:0]),
      .rd_data (t_rdata)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_count_ff <= tfe_pkg::CNT_W'(1);
         trans_count_ff <= tfe_pkg::CNT_W'(1);
         started_ff     <= 1'b0;
         cur_slot_ff    <= '0;
         run_ff         <= 1'b0;
         pend_ff        <= 1'b0;
         lookup_ff      <= 1'b0;
         ptr_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            if (csr_index == tfe_pkg::CSR_STATE_COUNT) begin
               state_count_ff <= csr_wdata;
            end else begin
               trans_count_ff <= csr_wdata;
            end
         end
         if (cmd.scan_start) begin
            run_ff    <= 1'b1;
            pend_ff   <= 1'b0;
            lookup_ff <= cmd.scan_lookup;
            ptr_ff    <= '0;
         end else begin
            if (stat.scan_done) begin
               run_ff <= 1'b0;
            end
            pend_ff <= issue;
            if (issue) begin
               ptr_ff <= ptr_ff + CW'(1);
            end
         end
         if (cmd.set_init || cmd.set_target) begin
            started_ff  <= 1'b1;
            cur_slot_ff <= SAW'(pend_addr_ff);
         end
         rsp_valid_ff <= cmd.respond;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         type_ff  <= tfe_pkg::req_code_type'(req_type);
         idx_ff   <= req_entry_index;
         sid_ff   <= req_state_id;
         ent_ff   <= req_has_entry_action;
         ext_ff   <= req_has_exit_action;
         doc_ff   <= req_do_action_count;
         from_ff  <= req_from_state_id;
         to_ff    <= req_to_state_id;
         sel_ff   <= req_condition_select;
         pres_ff  <= req_condition_present;
         conds_ff <= req_condition_bits;
         exs_ff   <= 1'b0;
         ens_ff   <= 1'b0;
         trd_ff   <= 1'b0;
         taken_ff <= '0;
         prev_ff  <= started_ff ? cur_id_ff : '0;
         dc_ff    <= ((tfe_pkg::req_code_type'(req_type) == tfe_pkg::REQ_RUN) && started_ff)
                     ? dc_sat : '0;
      end
      if (issue) begin
         pend_addr_ff <= ptr_ff[AW-1:0];
      end
      // winning transition
      if (hit_now && !lookup_ff) begin
         taken_ff <= tfe_pkg::IDX_W'(pend_addr_ff);
         tgt_ff   <= t_rdata[IW +: IW];
      end
      // a load into the current slot keeps the cache coherent
      if (s_we && (SAW'(idx_ff) == cur_slot_ff)) begin
         cur_id_ff   <= sid_ff;
         cur_attr_ff <= {doc_ff, ext_ff, ent_ff};
      end
      if (cmd.set_init || cmd.set_target) begin
         cur_id_ff   <= s_rdata[IW-1:0];
         cur_attr_ff <= s_rdata[tfe_pkg::SENT_W-1:IW];
         ens_ff      <= s_rdata[IW];
      end
      if (cmd.set_target) begin
         exs_ff <= cur_attr_ff[1];
         trd_ff <= 1'b1;
      end
      if (cmd.respond) begin
         rsp_status_ff <= cmd.resp_status;
         rsp_cur_ff    <= started_ff ? cur_id_ff : '0;
         rsp_cv_ff     <= started_ff;
         rsp_trd_ff    <= trd_ff;
         rsp_exs_ff    <= exs_ff;
         rsp_ens_ff    <= ens_ff;
         rsp_dc_ff     <= dc_ff;
         rsp_prev_ff   <= prev_ff;
         rsp_taken_ff  <= taken_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_current_state_id  = rsp_cur_ff;
   assign rsp_current_valid     = rsp_cv_ff;
   assign rsp_transitioned      = rsp_trd_ff;
   assign rsp_exit_strobe       = rsp_exs_ff;
   assign rsp_entry_strobe      = rsp_ens_ff;
   assign rsp_do_count          = rsp_dc_ff;
   assign rsp_previous_state_id = rsp_prev_ff;
   assign rsp_taken_index       = rsp_taken_ff;

endmodule

// ----- sim/testbench.sv -----
module testbench;

   localparam int TABLE_DEPTH    = 64;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 200;
   localparam int PHASES         = 10;
   localparam int PHASE_ITEMS    = 75;

   // one request as the sender sees it
   typedef struct {
      tfe_pkg::req_code_type kind;
      logic [5:0]    slot;
      logic [7:0]    sid;
      logic          ent;
      logic          ext;
      logic [3:0]    docnt;
      logic [7:0]    from_id;
      logic [7:0]    to_id;
      logic [4:0]    sel;
      logic          present;
      logic [31:0]   conds;
   } fsm_request_type;

   // one result as the engine reports it
   typedef struct {
      tfe_pkg::status_type status;
      logic [7:0]    cur_id;
      logic          cur_valid;
      logic          moved;
      logic          exit_s;
      logic          entry_s;
      logic [3:0]    do_cnt;
      logic [7:0]    prev_id;
      logic [5:0]    taken;
   } fsm_result_type;

   // directed row: request plus an optional hand-written result
   typedef struct {
      fsm_request_type req;
      bit              typed;
      fsm_result_type  res;
   } directed_row_type;

   logic          clock;
   logic          reset;
   logic          start;
   logic          busy;
   logic [1:0]    req_type;
   logic [5:0]    req_entry_index;
   logic [7:0]    req_state_id;
   logic          req_has_entry_action;
   logic          req_has_exit_action;
   logic [3:0]    req_do_action_count;
   logic [7:0]    req_from_state_id;
   logic [7:0]    req_to_state_id;
   logic [4:0]    req_condition_select;
   logic          req_condition_present;
   logic [31:0]   req_condition_bits;
   logic          rsp_valid;
   logic [1:0]    rsp_status;
   logic [7:0]    rsp_current_state_id;
   logic          rsp_current_valid;
   logic          rsp_transitioned;
   logic          rsp_exit_strobe;
   logic          rsp_entry_strobe;
   logic [3:0]    rsp_do_count;
   logic [7:0]    rsp_previous_state_id;
   logic [5:0]    rsp_taken_index;
   logic          csr_valid;
   logic          csr_ready;
   logic          csr_index;
   logic [6:0]    csr_wdata;

   table_driven_fsm_engine DUT (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_type              (req_type),
      .req_entry_index       (req_entry_index),
      .req_state_id          (req_state_id),
      .req_has_entry_action  (req_has_entry_action),
      .req_has_exit_action   (req_has_exit_action),
      .req_do_action_count   (req_do_action_count),
      .req_from_state_id     (req_from_state_id),
      .req_to_state_id       (req_to_state_id),
      .req_condition_select  (req_condition_select),
      .req_condition_present (req_condition_present),
      .req_condition_bits    (req_condition_bits),
      .rsp_valid             (rsp_valid),
      .rsp_status            (rsp_status),
      .rsp_current_state_id  (rsp_current_state_id),
      .rsp_current_valid     (rsp_current_valid),
      .rsp_transitioned      (rsp_transitioned),
      .rsp_exit_strobe       (rsp_exit_strobe),
      .rsp_entry_strobe      (rsp_entry_strobe),
      .rsp_do_count          (rsp_do_count),
      .rsp_previous_state_id (rsp_previous_state_id),
      .rsp_taken_index       (rsp_taken_index),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   // shadow copy of the engine tables and control state
   logic [7:0]    tbl_id     [TABLE_DEPTH];
   logic [5:0]    tbl_attr   [TABLE_DEPTH];
   logic [7:0]    tr_from    [TABLE_DEPTH];
   logic [7:0]    tr_to      [TABLE_DEPTH];
   logic [4:0]    tr_sel     [TABLE_DEPTH];
   logic          tr_present [TABLE_DEPTH];
   int unsigned   cur_slot       = 0;
   bit            engine_started = 1'b0;
   int unsigned   n_states       = 1;
   int unsigned   n_trans        = 1;

   fsm_result_type pending_results[$];
   logic [7:0]    id_pool[$];
   int            errors       = 0;
   int            quiet_cycles = 0;

   // free-running clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // lowest state slot holding id, within the active state count
   function automatic bit find_state_slot(input logic [7:0] id, output int unsigned slot);
      int unsigned lim;
      lim = (n_states > TABLE_DEPTH) ? TABLE_DEPTH : n_states;
      slot = 0;
      for (int unsigned i = 0; i < lim; i++) begin
         if (tbl_id[i] == id) begin
            slot = i;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // next-state and result computation for one accepted request
   function automatic fsm_result_type engine_step(input fsm_request_type r);
      fsm_result_type res;
      int unsigned   lim;
      int unsigned   tgt;
      logic [7:0]    cid;
      res.status  = tfe_pkg::ST_OK;
      res.moved   = 1'b0;
      res.exit_s  = 1'b0;
      res.entry_s = 1'b0;
      res.do_cnt  = 4'd0;
      res.taken   = 6'd0;
      res.prev_id = engine_started ? tbl_id[cur_slot] : 8'h00;
      case (r.kind)
         tfe_pkg::REQ_WRITE_STATE: begin
            tbl_id[r.slot]   = r.sid;
            tbl_attr[r.slot] = {r.docnt, r.ext, r.ent};
         end
         tfe_pkg::REQ_WRITE_TRANS: begin
            tr_from[r.slot]    = r.from_id;
            tr_to[r.slot]      = r.to_id;
            tr_sel[r.slot]     = r.sel;
            tr_present[r.slot] = r.present;
         end
         tfe_pkg::REQ_SET_INIT: begin
            // re-entry while running fires entry only, never exit
            if (find_state_slot(r.sid, tgt)) begin
               cur_slot       = tgt;
               engine_started = 1'b1;
               res.entry_s    = tbl_attr[tgt][0];
            end else begin
               res.status = tfe_pkg::ST_INIT_NOT_FOUND;
            end
         end
         default: begin
            if (!engine_started) begin
               res.status = tfe_pkg::ST_NOT_STARTED;
            end else begin
               cid        = tbl_id[cur_slot];
               res.do_cnt = tbl_attr[cur_slot][5:2];
               lim        = (n_trans > TABLE_DEPTH) ? TABLE_DEPTH : n_trans;
               // first present entry from the current id with a true condition wins
               for (int unsigned i = 0; i < lim; i++) begin
                  if (tr_from[i] == cid && tr_present[i] && r.conds[tr_sel[i]]) begin
                     res.taken = i[5:0];
                     if (find_state_slot(tr_to[i], tgt)) begin
                        res.exit_s  = tbl_attr[cur_slot][1];
                        cur_slot    = tgt;
                        res.entry_s = tbl_attr[tgt][0];
                        res.moved   = 1'b1;
                     end else begin
                        // missing target still ends the scan
                        res.status = tfe_pkg::ST_TARGET_MISSING;
                     end
                     break;
                  end
               end
            end
         end
      endcase
      res.cur_id    = engine_started ? tbl_id[cur_slot] : 8'h00;
      res.cur_valid = engine_started;
      return res;
   endfunction

   function automatic fsm_request_type mk_req(input tfe_pkg::req_code_type kind,
                                              input logic [5:0] slot,
                                              input logic [7:0] sid, input logic ent,
                                              input logic ext, input logic [3:0] docnt,
                                              input logic [7:0] from_id,
                                              input logic [7:0] to_id,
                                              input logic [4:0] sel, input logic present,
                                              input logic [31:0] conds);
      fsm_request_type r;
      r.kind    = kind;
      r.slot    = slot;
      r.sid     = sid;
      r.ent     = ent;
      r.ext     = ext;
      r.docnt   = docnt;
      r.from_id = from_id;
      r.to_id   = to_id;
      r.sel     = sel;
      r.present = present;
      r.conds   = conds;
      return r;
   endfunction

   function automatic fsm_result_type mk_res(input tfe_pkg::status_type status,
                                             input logic [7:0] cur_id,
                                             input logic cur_valid, input logic moved,
                                             input logic exit_s, input logic entry_s,
                                             input logic [3:0] do_cnt,
                                             input logic [7:0] prev_id,
                                             input logic [5:0] taken);
      fsm_result_type res;
      res.status    = status;
      res.cur_id    = cur_id;
      res.cur_valid = cur_valid;
      res.moved     = moved;
      res.exit_s    = exit_s;
      res.entry_s   = entry_s;
      res.do_cnt    = do_cnt;
      res.prev_id   = prev_id;
      res.taken     = taken;
      return res;
   endfunction

   function automatic directed_row_type row(input fsm_request_type req, input bit typed,
                                            input fsm_result_type res);
      directed_row_type d;
      d.req   = req;
      d.typed = typed;
      d.res   = res;
      return d;
   endfunction

   // mostly ids of the current pool so lookups and transitions hit
   function automatic logic [7:0] pick_id();
      if (id_pool.size() == 0 || $urandom_range(0, 9) == 0)
         return 8'($urandom_range(0, 255));
      return id_pool[$urandom_range(0, id_pool.size() - 1)];
   endfunction

   function automatic logic [5:0] pick_slot(input int unsigned count);
      int unsigned lim;
      lim = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
      if (lim > 0 && $urandom_range(0, 9) < 7)
         return 6'($urandom_range(0, lim - 1));
      return 6'($urandom_range(0, TABLE_DEPTH - 1));
   endfunction

   // random request: noise in every field, then the fields that matter shaped
   function automatic fsm_request_type rand_request();
      fsm_request_type r;
      int            roll;
      int            shape;
      int unsigned   lim_s;
      r = mk_req(tfe_pkg::REQ_RUN, 6'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                 4'($urandom), 8'($urandom), 8'($urandom), 5'($urandom), 1'($urandom),
                 $urandom);
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
         r.kind = tfe_pkg::REQ_RUN;
         shape  = $urandom_range(0, 9);
         // random, all-ones, one-hot or empty conditions; sparse ones push scans deep into the table
         if (shape >= 4 && shape <= 5)
            r.conds = 32'hFFFF_FFFF;
         else if (shape >= 6 && shape <= 8)
            r.conds = 32'h1 << $urandom_range(0, 31);
         else if (shape == 9)
            r.conds = 32'h0;
      end else if (roll < 65) begin
         r.kind = tfe_pkg::REQ_WRITE_STATE;
         r.slot = pick_slot(n_states);
         r.sid  = pick_id();
      end else if (roll < 85) begin
         r.kind    = tfe_pkg::REQ_WRITE_TRANS;
         r.slot    = pick_slot(n_trans);
         r.from_id = pick_id();
         r.to_id   = ($urandom_range(0, 9) == 0) ? 8'($urandom) : pick_id();
         r.present = ($urandom_range(0, 99) < 85);
      end else begin
         r.kind = tfe_pkg::REQ_SET_INIT;
         lim_s  = (n_states > TABLE_DEPTH) ? TABLE_DEPTH : n_states;
         if (lim_s > 0 && $urandom_range(0, 9) < 7)
            r.sid = tbl_id[$urandom_range(0, lim_s - 1)];
         else
            r.sid = pick_id();
      end
      return r;
   endfunction

   // gap lengths: mostly short, a few long, none in calm stretches
   function automatic int pick_gap(input bit calm);
      int roll;
      if (calm)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 40) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 80);
   endfunction

   function automatic void refresh_pool(input bit from_table);
      id_pool.delete();
      repeat ($urandom_range(2, 5)) id_pool.push_back(8'($urandom_range(0, 255)));
      if (from_table)
         repeat (3) id_pool.push_back(tbl_id[$urandom_range(0, TABLE_DEPTH - 1)]);
   endfunction

   // drive one request and hold it until the engine takes it
   task automatic send_request(input fsm_request_type r, input bit typed,
                               input fsm_result_type res);
      fsm_result_type predicted;
      start                 <= 1'b1;
      req_type              <= r.kind;
      req_entry_index       <= r.slot;
      req_state_id          <= r.sid;
      req_has_entry_action  <= r.ent;
      req_has_exit_action   <= r.ext;
      req_do_action_count   <= r.docnt;
      req_from_state_id     <= r.from_id;
      req_to_state_id       <= r.to_id;
      req_condition_select  <= r.sel;
      req_condition_present <= r.present;
      req_condition_bits    <= r.conds;
      do @(posedge clock); while (busy);
      // shadow state always advances, hand-written rows override the result
      predicted = engine_step(r);
      pending_results.push_back(typed ? res : predicted);
   endtask

   task automatic idle_gap(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // hold off until every result is back and the engine is free
   task automatic wait_idle();
      start <= 1'b0;
      while (pending_results.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic write_counts(input logic [6:0] states, input logic [6:0] trans);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= tfe_pkg::CSR_STATE_COUNT;
      csr_wdata <= states;
      do @(posedge clock); while (!csr_ready);
      n_states  = states;
      csr_index <= tfe_pkg::CSR_TRANSITION_COUNT;
      csr_wdata <= trans;
      do @(posedge clock); while (!csr_ready);
      n_trans   = trans;
      csr_valid <= 1'b0;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         errors++;
      end
   endtask

   // result side: strobe is always taken, compare against the oldest expectation
   always @(posedge clock) begin
      fsm_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("result strobe with no request outstanding");
            errors++;
         end else begin
            want = pending_results.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("current_state_id", want.cur_id, rsp_current_state_id);
            check_field("current_valid", want.cur_valid, rsp_current_valid);
            check_field("transitioned", want.moved, rsp_transitioned);
            check_field("exit_strobe", want.exit_s, rsp_exit_strobe);
            check_field("entry_strobe", want.entry_s, rsp_entry_strobe);
            check_field("do_count", want.do_cnt, rsp_do_count);
            check_field("previous_state_id", want.prev_id, rsp_previous_state_id);
            check_field("taken_index", want.taken, rsp_taken_index);
         end
      end
   end

   // watchdog on cycles with no handshake of any kind
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      directed_row_type plan[$];
      fsm_request_type  r;
      fsm_result_type   blank;
      logic [6:0]    s_cnt;
      logic [6:0]    t_cnt;
      bit            calm;

      reset                 <= 1'b1;
      start                 <= 1'b0;
      req_type              <= tfe_pkg::REQ_RUN;
      req_entry_index       <= '0;
      req_state_id          <= '0;
      req_has_entry_action  <= 1'b0;
      req_has_exit_action   <= 1'b0;
      req_do_action_count   <= '0;
      req_from_state_id     <= '0;
      req_to_state_id       <= '0;
      req_condition_select  <= '0;
      req_condition_present <= 1'b0;
      req_condition_bits    <= '0;
      csr_valid             <= 1'b0;
      csr_index             <= tfe_pkg::CSR_STATE_COUNT;
      csr_wdata             <= '0;
      blank = mk_res(tfe_pkg::ST_OK, 0, 0, 0, 0, 0, 0, 0, 0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed part at reset counts: one state slot and one transition slot searched
      // run before any initial state
      plan.push_back(row(mk_req(tfe_pkg::REQ_RUN, 6'd63, 8'hFF, 1, 1, 4'hF, 8'hFF, 8'hFF,
                                5'd31, 1, 32'hFFFF_FFFF), 1,
                         mk_res(tfe_pkg::ST_NOT_STARTED, 8'h00, 0, 0, 0, 0, 4'd0, 8'h00,
                                6'd0)));
      plan.push_back(row(mk_req(tfe_pkg::REQ_WRITE_STATE, 6'd0, 8'hFF, 1, 1, 4'hF,
                                0, 0, 0, 0, 0), 1,
                         mk_res(tfe_pkg::ST_OK, 8'h00, 0, 0, 0, 0, 4'd0, 8'h00, 6'd0)));
      // initial id not in the table
      plan.push_back(row(mk_req(tfe_pkg::REQ_SET_INIT, 6'd0, 8'h00, 0, 0, 0,
                                0, 0, 0, 0, 0), 1,
                         mk_res(tfe_pkg::ST_INIT_NOT_FOUND, 8'h00, 0, 0, 0, 0, 4'd0,
                                8'h00, 6'd0)));
      plan.push_back(row(mk_req(tfe_pkg::REQ_SET_INIT, 6'd0, 8'hFF, 0, 0, 0,
                                0, 0, 0, 0, 0), 1,
                         mk_res(tfe_pkg::ST_OK, 8'hFF, 1, 0, 0, 1, 4'd0, 8'h00, 6'd0)));
      // self transition on the top condition bit
      plan.push_back(row(mk_req(tfe_pkg::REQ_WRITE_TRANS, 6'd0, 0, 0, 0, 0,
                                8'hFF, 8'hFF, 5'd31, 1, 0), 1,
                         mk_res(tfe_pkg::ST_OK, 8'hFF, 1, 0, 0, 0, 4'd0, 8'hFF, 6'd0)));
      plan.push_back(row(mk_req(tfe_pkg::REQ_RUN, 6'd0, 0, 0, 0, 0,
                                0, 0, 0, 0, 32'h0), 1,
                         mk_res(tfe_pkg::ST_OK, 8'hFF, 1, 0, 0, 0, 4'hF, 8'hFF, 6'd0)));
      plan.push_back(row(mk_req(tfe_pkg::REQ_RUN, 6'd0, 0, 0, 0, 0,
                                0, 0, 0, 0, 32'h8000_0000), 1,
                         mk_res(tfe_pkg::ST_OK, 8'hFF, 1, 1, 1, 1, 4'hF, 8'hFF, 6'd0)));
      // set initial while running, found and not found
      plan.push_back(row(mk_req(tfe_pkg::REQ_SET_INIT, 6'd0, 8'hFF, 0, 0, 0,
                                0, 0, 0, 0, 0), 1,
                         mk_res(tfe_pkg::ST_OK, 8'hFF, 1, 0, 0, 1, 4'd0, 8'hFF, 6'd0)));
      plan.push_back(row(mk_req(tfe_pkg::REQ_SET_INIT, 6'd0, 8'h00, 0, 0, 0,
                                0, 0, 0, 0, 0), 1,
                         mk_res(tfe_pkg::ST_INIT_NOT_FOUND, 8'hFF, 1, 0, 0, 0, 4'd0,
                                8'hFF, 6'd0)));
      // target id missing from the state table
      plan.push_back(row(mk_req(tfe_pkg::REQ_WRITE_TRANS, 6'd0, 0, 0, 0, 0,
                                8'hFF, 8'h12, 5'd0, 1, 0), 1,
                         mk_res(tfe_pkg::ST_OK, 8'hFF, 1, 0, 0, 0, 4'd0, 8'hFF, 6'd0)));
      plan.push_back(row(mk_req(tfe_pkg::REQ_RUN, 6'd0, 0, 0, 0, 0,
                                0, 0, 0, 0, 32'h1), 1,
                         mk_res(tfe_pkg::ST_TARGET_MISSING, 8'hFF, 1, 0, 0, 0, 4'hF,
                                8'hFF, 6'd0)));
      // transition without a condition is never taken
      plan.push_back(row(mk_req(tfe_pkg::REQ_WRITE_TRANS, 6'd0, 0, 0, 0, 0,
                                8'hFF, 8'hFF, 5'd5, 0, 0), 1,
                         mk_res(tfe_pkg::ST_OK, 8'hFF, 1, 0, 0, 0, 4'd0, 8'hFF, 6'd0)));
      plan.push_back(row(mk_req(tfe_pkg::REQ_RUN, 6'd0, 0, 0, 0, 0,
                                0, 0, 0, 0, 32'hFFFF_FFFF), 1,
                         mk_res(tfe_pkg::ST_OK, 8'hFF, 1, 0, 0, 0, 4'hF, 8'hFF, 6'd0)));
      // rewrite of the current slot changes the current id
      plan.push_back(row(mk_req(tfe_pkg::REQ_WRITE_STATE, 6'd0, 8'h00, 0, 0, 4'h0,
                                0, 0, 0, 0, 0), 0, blank));
      plan.push_back(row(mk_req(tfe_pkg::REQ_RUN, 6'd0, 0, 0, 0, 0,
                                0, 0, 0, 0, 32'hFFFF_FFFF), 0, blank));
      plan.push_back(row(mk_req(tfe_pkg::REQ_SET_INIT, 6'd0, 8'h00, 0, 0, 0,
                                0, 0, 0, 0, 0), 0, blank));
      // top slots, outside the active counts
      plan.push_back(row(mk_req(tfe_pkg::REQ_WRITE_STATE, 6'd63, 8'hFF, 1, 1, 4'hF,
                                8'hFF, 8'hFF, 5'd31, 1, 32'hFFFF_FFFF), 0, blank));
      plan.push_back(row(mk_req(tfe_pkg::REQ_WRITE_TRANS, 6'd63, 8'hFF, 1, 1, 4'hF,
                                8'h00, 8'h00, 5'd31, 1, 32'hFFFF_FFFF), 0, blank));

      foreach (plan[i]) begin
         send_request(plan[i].req, plan[i].typed, plan[i].res);
         idle_gap(pick_gap(1'b0));
      end

      // fill every slot of both tables so no later search meets an unwritten entry
      refresh_pool(1'b0);
      for (int s = 0; s < TABLE_DEPTH; s++) begin
         r      = rand_request();
         r.kind = tfe_pkg::REQ_WRITE_STATE;
         r.slot = 6'(s);
         r.sid  = pick_id();
         send_request(r, 1'b0, blank);
         idle_gap(pick_gap(1'b0));
         r         = rand_request();
         r.kind    = tfe_pkg::REQ_WRITE_TRANS;
         r.slot    = 6'(s);
         r.from_id = pick_id();
         r.to_id   = pick_id();
         send_request(r, 1'b0, blank);
         idle_gap(pick_gap(1'b0));
      end

      // random phases, each under its own pair of counts
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin s_cnt = 7'd64;  t_cnt = 7'd64;  end
            1: begin s_cnt = 7'd1;   t_cnt = 7'd1;   end
            2: begin s_cnt = 7'd0;   t_cnt = 7'd0;   end
            3: begin s_cnt = 7'd127; t_cnt = 7'd127; end
            4: begin s_cnt = 7'd8;   t_cnt = 7'd16;  end
            5: begin s_cnt = 7'd64;  t_cnt = 7'd1;   end
            6: begin s_cnt = 7'd1;   t_cnt = 7'd64;  end
            8: begin s_cnt = 7'd100; t_cnt = 7'd3;   end
            default: begin
               s_cnt = 7'($urandom_range(1, 64));
               t_cnt = 7'($urandom_range(1, 64));
            end
         endcase
         write_counts(s_cnt, t_cnt);
         refresh_pool(1'b1);
         calm = (p % 3 == 1);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            send_request(rand_request(), 1'b0, blank);
            // now and then drain completely before the next request
            if ($urandom_range(0, 99) < 3)
               wait_idle();
            else
               idle_gap(pick_gap(calm));
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && pending_results.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
